### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and codes of the pending signal table.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_RAISE   = 2'd0;
  localparam mode_t MODE_ACQUIRE = 2'd1;
  localparam mode_t MODE_QUERY   = 2'd2;
  localparam mode_t MODE_CLEAR   = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_EXISTS  = 2'd2;
  localparam status_t ST_NONE    = 2'd3;

  localparam int NUM_W  = 6;
  localparam int WORD_W = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request word
    logic exec;     // update the bitmap, read and on a raise write the payload store
    logic load;     // fill the output register
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/pst_req_if.sv
// ----------------------------------------------------------------------------
// pst_req_if
// Request channel of the pending signal table: valid/ready plus request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_req_if
  import pst_pkg::*;
;
  logic                valid;
  logic                ready;
  mode_t               mode;
  logic [NUM_W-1:0]    signal_number;
  logic [WORD_W-1:0]   signal_payload;
  logic [WORD_W-1:0]   block_mask;

  modport source (output valid, mode, signal_number, signal_payload, block_mask,
                  input ready);
  modport sink   (input valid, mode, signal_number, signal_payload, block_mask,
                  output ready);
endinterface

`default_nettype wire

### rtl/pst_rsp_if.sv
// ----------------------------------------------------------------------------
// pst_rsp_if
// Response channel of the pending signal table: valid/ready plus result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_rsp_if
  import pst_pkg::*;
;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [NUM_W-1:0]    found_number;
  logic [WORD_W-1:0]   found_payload;
  logic                any_pending;

  modport source (output valid, status, found_number, found_payload, any_pending,
                  input ready);
  modport sink   (input valid, status, found_number, found_payload, any_pending,
                  output ready);
endinterface

`default_nettype wire

### rtl/pending_signal_table_unit.sv
// ----------------------------------------------------------------------------
// pending_signal_table_unit
// Pending signal bitmap with payload store and lowest-number-first acquire.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (mode, signal_number, signal_payload,
//   block_mask); rsp returns exactly one result word per request, in order.
//   Both channels move a word when valid and ready are high at a clock edge.
//   Each request goes through capture, execute (bitmap update, a read of
//   the payload store and, for a raise, a write to it), then load of the
//   output register. The next request is taken only once the result is
//   loaded: the block takes no new word before it is through with the last.
//   A stalled rsp holds its word; one further request is accepted and
//   executed, then waits until the output register frees up.
//   Reset (rst, synchronous) clears all pending bits and both channels'
//   control state. The payload store has no reset; its read data is only
//   used after a raise has written the entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_signal_table_unit
  import pst_pkg::*;
#(
  parameter int NUM_SIGNALS  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  pst_req_if.sink   req,
  pst_rsp_if.source rsp
);

  dp_cmd_t cmd;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  pst_dp #(
    .NUM_SIGNALS  (NUM_SIGNALS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .mode           (req.mode),
    .signal_number  (req.signal_number),
    .signal_payload (req.signal_payload),
    .block_mask     (req.block_mask),
    .status         (rsp.status),
    .found_number   (rsp.found_number),
    .found_payload  (rsp.found_payload),
    .any_pending    (rsp.any_pending)
  );

endmodule

`default_nettype wire

### rtl/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer of the pending signal table: takes one request word, runs the
// update and store access, then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted word did not start execution");

  a_exec_then_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_RESP))
    else $error("execution step not followed by response step");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (out_valid && state == S_IDLE))
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

### rtl/pst_dp.sv
// ----------------------------------------------------------------------------
// pst_dp
// Datapath of the pending signal table: pending bitmap, lowest-first select,
// payload store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_dp
  import pst_pkg::*;
#(
  parameter int NUM_SIGNALS  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  input  wire mode_t             mode,
  input  wire logic [NUM_W-1:0]  signal_number,
  input  wire logic [WORD_W-1:0] signal_payload,
  input  wire logic [WORD_W-1:0] block_mask,
  output status_t                status,
  output logic [NUM_W-1:0]       found_number,
  output logic [WORD_W-1:0]      found_payload,
  output logic                   any_pending
);

  localparam int NP    = NUM_SIGNALS - 1;
  localparam int IDX_W = (NP > 1) ? $clog2(NP) : 1;

  // request word
  mode_t                   mode_q;
  logic [NUM_W-1:0]        num_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [NP-1:0]           mask_q;

  logic [NP-1:0]           pending;
  logic [NP-1:0]           pending_next;

  logic [PAYLOAD_BITS-1:0] mem [NP];
  logic [PAYLOAD_BITS-1:0] rd_data;

  // execution results
  status_t                 st_q;
  logic [NUM_W-1:0]        fnum_q;
  logic                    hit_q;
  logic                    any_q;

  logic                    num_ok;
  logic [NUM_W-1:0]        num_m1;
  logic [IDX_W-1:0]        raise_idx;
  logic                    dup;
  logic                    raise_wr;
  logic [NP-1:0]           ready_v;
  logic                    found;
  logic [IDX_W-1:0]        sel_idx;
  status_t                 st_next;
  logic                    hit_next;

  assign num_ok    = (num_q != '0) && ({1'b0, num_q} < (NUM_W + 1)'(NUM_SIGNALS));
  assign num_m1    = num_q - NUM_W'(1);
  assign raise_idx = num_m1[IDX_W-1:0];
  assign dup       = num_ok && pending[raise_idx];
  assign ready_v   = pending & ~mask_q;
  assign found     = |ready_v;

  // lowest set bit wins
  always_comb begin
    sel_idx = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (ready_v[i]) sel_idx = IDX_W'(i);
    end
  end

  always_comb begin
    pending_next = pending;
    st_next      = ST_OK;
    hit_next     = 1'b0;
    raise_wr     = 1'b0;
    unique case (mode_q)
      MODE_RAISE: begin
        if (!num_ok) begin
          st_next = ST_INVALID;
        end else if (dup) begin
          st_next = ST_EXISTS;
        end else begin
          raise_wr     = 1'b1;
          pending_next = pending | (NP'(1) << raise_idx);
        end
      end
      MODE_ACQUIRE: begin
        if (!found) begin
          st_next = ST_NONE;
        end else begin
          hit_next     = 1'b1;
          pending_next = pending & ~(NP'(1) << sel_idx);
        end
      end
      MODE_CLEAR: pending_next = '0;
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      num_q  <= signal_number;
      pay_q  <= signal_payload[PAYLOAD_BITS-1:0];
      mask_q <= block_mask[NP-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.exec) begin
      pending <= pending_next;
    end
  end

  // payload store: one registered read per execution step, plus a write on a raise
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (raise_wr) begin
        mem[raise_idx] <= pay_q;
      end
      rd_data <= mem[sel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_q   <= st_next;
      hit_q  <= hit_next;
      fnum_q <= hit_next ? (NUM_W'(sel_idx) + NUM_W'(1)) : '0;
      any_q  <= |pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status        <= st_q;
      found_number  <= fnum_q;
      found_payload <= hit_q ? WORD_W'(rd_data) : '0;
      any_pending   <= any_q;
    end
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && mode_q == MODE_CLEAR) |=> (pending == '0))
    else $error("clear left pending bits");

  a_acquire_drops_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && mode_q == MODE_ACQUIRE && found) |=>
      ($countones(pending) == $countones($past(pending)) - 1))
    else $error("acquire did not drop exactly one pending bit");

  a_raise_adds_one: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && raise_wr) |=>
      ($countones(pending) == $countones($past(pending)) + 1))
    else $error("raise did not add exactly one pending bit");
`endif

endmodule

`default_nettype wire

### bench/pst_result_check.sv
// ----------------------------------------------------------------------------
// pst_result_check
// Watches both channels of the pending signal table, keeps its own copy of
// the pending bitmap and payload store, and compares every result word with
// the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pst_result_check
  import pst_pkg::*;
#(
  parameter int NUM_SIGNALS  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  pst_req_if   req,
  pst_rsp_if   rsp,
  output int   fail_count,
  output int   open_count
);

  typedef struct {
    status_t          status;
    logic [NUM_W-1:0] number;
    logic [WORD_W-1:0] payload;
    logic             any;
  } table_result_t;

  // Signals 1 .. NUM_SIGNALS-1 live in bits 0 .. NUM_SIGNALS-2.
  localparam logic [WORD_W-1:0] LIVE_RANGE = (64'd1 << (NUM_SIGNALS - 1)) - 64'd1;
  localparam logic [WORD_W-1:0] PAY_MASK =
    (PAYLOAD_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << PAYLOAD_BITS) - 64'd1);

  logic [WORD_W-1:0] pending_map;
  logic [WORD_W-1:0] info_words [WORD_W];
  table_result_t     due_results [$];

  function automatic table_result_t table_step(mode_t m, logic [NUM_W-1:0] num,
                                               logic [WORD_W-1:0] pay,
                                               logic [WORD_W-1:0] mask);
    table_result_t     r;
    logic [WORD_W-1:0] live;
    int                slot;
    r.status  = ST_OK;
    r.number  = '0;
    r.payload = '0;
    slot = int'(num) - 1;
    case (m)
      MODE_RAISE: begin
        if (num == 0 || num >= NUM_SIGNALS) begin
          r.status = ST_INVALID;
        end else if (pending_map[slot]) begin
          // keep the stored payload of the pending signal
          r.status = ST_EXISTS;
        end else begin
          info_words[slot]  = pay & PAY_MASK;
          pending_map[slot] = 1'b1;
        end
      end
      MODE_ACQUIRE: begin
        live = pending_map & ~mask & LIVE_RANGE;
        if (live == '0) begin
          r.status = ST_NONE;
        end else begin
          slot = 0;
          while (!live[slot]) slot++;
          r.number          = NUM_W'(slot + 1);
          r.payload         = info_words[slot] & PAY_MASK;
          pending_map[slot] = 1'b0;
        end
      end
      MODE_QUERY: ;
      MODE_CLEAR: pending_map = '0;
    endcase
    r.any = (pending_map != '0);
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      pending_map = '0;
      due_results.delete();
    end else begin
      // retire the outgoing word first: it never belongs to this edge's request
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with none due: status=%0d num=%0d pay=%h any=%0d",
                     $time, rsp.status, rsp.found_number, rsp.found_payload,
                     rsp.any_pending);
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status || rsp.found_number !== want.number ||
              rsp.found_payload !== want.payload || rsp.any_pending !== want.any) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: want status=%0d num=%0d pay=%h any=%0d, got status=%0d num=%0d pay=%h any=%0d",
                       $time, want.status, want.number, want.payload, want.any,
                       rsp.status, rsp.found_number, rsp.found_payload,
                       rsp.any_pending);
          end
        end
      end
      if (req.valid && req.ready)
        due_results.push_back(table_step(req.mode, req.signal_number,
                                         req.signal_payload, req.block_mask));
    end
    open_count = due_results.size();
  end

endmodule

### bench/pending_signal_table_unit_test.sv
// ----------------------------------------------------------------------------
// pending_signal_table_unit_test
// Drives raise, acquire, query and clear words into the pending signal table
// with random gaps and output stalls; the result checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pending_signal_table_unit_test
  import pst_pkg::*;
;

  localparam int NUM_SIGNALS  = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 200;
  localparam int CALM_WORDS   = 50;
  localparam int LIMIT        = 400000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   open_count;
  int   stall_odds;
  int   gap_odds;
  int   raise_pct;
  int   cycle_count;

  pst_req_if req ();
  pst_rsp_if rsp ();

  pending_signal_table_unit #(
    .NUM_SIGNALS (NUM_SIGNALS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  pst_result_check #(
    .NUM_SIGNALS (NUM_SIGNALS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_result_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .fail_count(fail_count),
    .open_count(open_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pending_signal_table_unit_test: errors");
    $finish;
  end

  // Output stalls come in random bursts, at the rate of the current phase.
  initial begin
    int hold;
    hold = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0)
        hold--;
      else if ($urandom_range(1, 100) <= stall_odds)
        hold = $urandom_range(1, 5);
      rsp.ready <= (hold == 0);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(mode_t m, logic [NUM_W-1:0] num, logic [WORD_W-1:0] pay,
                           logic [WORD_W-1:0] mask);
    @(negedge clk);
    req.valid          <= 1'b1;
    req.mode           <= m;
    req.signal_number  <= num;
    req.signal_payload <= pay;
    req.block_mask     <= mask;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  // Hold the request side until every due result has come back.
  task automatic drain_table();
    @(negedge clk);
    req.valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  task automatic send_random();
    int                pick;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] mask;
    mode_t             m;
    if ($urandom_range(1, 100) <= gap_odds) idle_sender($urandom_range(1, 5));
    pick = $urandom_range(1, 100);
    if (pick <= raise_pct) m = MODE_RAISE;
    else if (pick <= raise_pct + 3) m = MODE_CLEAR;
    else if (pick <= raise_pct + 13) m = MODE_QUERY;
    else m = MODE_ACQUIRE;
    // favor low numbers so raises collide and priority order matters
    pick = $urandom_range(1, 20);
    if (pick == 1) num = '0;
    else if (pick <= 9) num = NUM_W'($urandom_range(1, 8));
    else num = NUM_W'($urandom_range(1, NUM_SIGNALS - 1));
    pick = $urandom_range(1, 10);
    if (pick <= 3) mask = '0;
    else if (pick == 4) mask = '1;
    else if (pick <= 6) mask = rand_word();
    else if (pick <= 9) mask = rand_word() & rand_word() & rand_word();
    else mask = ~(64'd1 << $urandom_range(0, 63));
    if (m != MODE_RAISE) num = NUM_W'($urandom);
    send_word(m, num, rand_word(), mask);
  endtask

  initial begin
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.mode           = MODE_QUERY;
    req.signal_number  = '0;
    req.signal_payload = '0;
    req.block_mask     = '0;
    stall_odds         = 0;
    gap_odds           = 0;
    raise_pct          = 50;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: edges of the number range, duplicates, masks, clear
    send_word(MODE_RAISE,   6'd0,  '1, '0);
    send_word(MODE_QUERY,   6'd0,  '0, '0);
    send_word(MODE_ACQUIRE, 6'd0,  '0, '0);
    send_word(MODE_RAISE,   6'd63, '1, '0);
    send_word(MODE_RAISE,   6'd1,  '0, '0);
    send_word(MODE_RAISE,   6'd1,  64'h5555_5555_5555_5555, '0);
    send_word(MODE_RAISE,   6'd32, 64'hA5A5_5A5A_0FF0_F00F, '1);
    send_word(MODE_QUERY,   6'd63, '1, '1);
    send_word(MODE_ACQUIRE, 6'd1,  '1, '1);
    send_word(MODE_ACQUIRE, 6'd0,  '0, ~(64'd1 << 62));
    send_word(MODE_ACQUIRE, 6'd63, '1, 64'h8000_0000_0000_0000);
    send_word(MODE_ACQUIRE, 6'd0,  '0, '0);
    send_word(MODE_ACQUIRE, 6'd0,  '0, '0);
    send_word(MODE_RAISE,   6'd5,  64'h0123_4567_89AB_CDEF, '0);
    send_word(MODE_RAISE,   6'd6,  64'hFEDC_BA98_7654_3210, '0);
    send_word(MODE_CLEAR,   6'd5,  '1, '1);
    send_word(MODE_ACQUIRE, 6'd0,  '0, '0);
    send_word(MODE_QUERY,   6'd0,  '0, '0);
    send_word(MODE_RAISE,   6'd5,  64'h8000_0000_0000_0001, '0);
    send_word(MODE_RAISE,   6'd63, '0, '0);
    send_word(MODE_ACQUIRE, 6'd0,  '0, 64'h0000_0000_0000_0010);
    send_word(MODE_ACQUIRE, 6'd0,  '0, '0);
    send_word(MODE_QUERY,   6'd0,  '0, '0);
    drain_table();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        stall_odds = $urandom_range(0, 30);
        gap_odds   = $urandom_range(0, 30);
      end
      raise_pct = $urandom_range(35, 70);
      repeat (PHASE_WORDS) send_random();
      if (p == PHASES / 2) drain_table();
    end

    // last stretch runs at full rate on both sides
    stall_odds = 0;
    gap_odds   = 0;
    repeat (CALM_WORDS) send_random();

    drain_table();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("pending_signal_table_unit_test: clean");
    else
      $display("pending_signal_table_unit_test: errors");
    $finish;
  end

endmodule
